// ===== src/esa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ascending exchange sort block.
// Holds the key width, the sequencer state type and the key store command struct.
// Depends on nothing.
package esa_pkg;

   // Width of one key and of one sorted result.
   localparam int KEY_WIDTH = 32;

   // Sequencer states: load the set, sort it, then drain it.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH_I,
      ST_HOLD_I,
      ST_FETCH_J,
      ST_CMP_J,
      ST_STORE_I,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } seq_state_type;

   // Port enables for the key store, issued by the sequencer.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_cmd_type;

endpackage

// ===== src/esa_channels.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// Depends on esa_pkg for the key width.

// Request channel: one key per request, with the end-of-set mark.
interface esa_req_if import esa_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_WIDTH-1:0] key_value;
   logic                        set_end;

   modport source (output valid, output key_value, output set_end, input ready);
   modport sink   (input valid, input key_value, input set_end, output ready);
endinterface

// Response channel: one sorted key per response, with the final-key mark.
interface esa_rsp_if import esa_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_WIDTH-1:0] sorted_value;
   logic                        final_key;

   modport source (output valid, output sorted_value, output final_key, input ready);
   modport sink   (input valid, input sorted_value, input final_key, output ready);
endinterface

// ===== src/exchange_sort_ascending.sv =====
`timescale 1ns / 1ps
// Top level of the ascending exchange sort block.
// Depends on esa_pkg, esa_channels, esa_key_store and esa_sequencer.
//
// Keys arrive one per request, one per cycle, and are stored until a request
// marked set_end arrives or the store holds MAX_KEYS keys. The block then sorts
// the set of N keys in place with a single signed comparator and a key store
// that has one write and one registered read port: position i is compared with
// each later position, the smaller key being kept and the greater written back.
// Each comparison reads the later key first, then compares and writes. The
// sorted keys are then returned in ascending order, each one read from the
// store before it is offered until taken, the last one flagged with final_key.
// No request is taken while a set is being sorted or returned; the store needs
// no clearing after reset.
module exchange_sort_ascending import esa_pkg::*; #(
   parameter int MAX_KEYS = 16
) (
   input logic       clock,
   input logic       reset,
   esa_req_if.sink   req_chan,
   esa_rsp_if.source rsp_chan
);

   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   store_cmd_type        cmd;
   logic [AW-1:0]        wr_addr;
   logic [KEY_WIDTH-1:0] wr_data;
   logic [AW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] rd_data;

   // Control: load, sort and drain.
   esa_sequencer #(
      .MAX_KEYS (MAX_KEYS)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_key   (req_chan.key_value),
      .req_end   (req_chan.set_end),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_final (rsp_chan.final_key),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // Key storage; its read register also serves as the response register.
   esa_key_store #(
      .DEPTH (MAX_KEYS)
   ) u_key_store (
      .clock   (clock),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_chan.sorted_value = $signed(rd_data);

endmodule

// ===== src/esa_key_store.sv =====
`timescale 1ns / 1ps
// Key store for the exchange sort: one write port and one registered read port.
// Depends on esa_pkg for the key width and the command struct.
module esa_key_store import esa_pkg::*; #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  store_cmd_type        cmd,
   input  logic [AW-1:0]        wr_addr,
   input  logic [KEY_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [KEY_WIDTH-1:0] rd_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   // The sequencer never reads and writes in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/esa_sequencer.sv =====
`timescale 1ns / 1ps
// Sequencer for the exchange sort: loads keys, runs the compare-exchange loop
// through one signed comparator, then drains the store in order.
// Depends on esa_pkg for the state type, the command struct and the key width.
module esa_sequencer import esa_pkg::*; #(
   parameter int MAX_KEYS = 16,
   localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
   localparam int CW = $clog2(MAX_KEYS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request side
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KEY_WIDTH-1:0] req_key,
   input  logic                 req_end,
   // Response side
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_final,
   // Key store
   output store_cmd_type        cmd,
   output logic [AW-1:0]        wr_addr,
   output logic [KEY_WIDTH-1:0] wr_data,
   output logic [AW-1:0]        rd_addr,
   input  logic [KEY_WIDTH-1:0] rd_data
);

   seq_state_type               state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               num_ff, num_in;
   logic [CW-1:0]               i_ff, i_in;
   logic [CW-1:0]               j_ff, j_in;
   logic [CW-1:0]               k_ff, k_in;
   logic signed [KEY_WIDTH-1:0] key_i_ff, key_i_in;
   logic                        key_greater;
   logic [CW-1:0]               count_next;
   logic [CW-1:0]               i_next;
   logic [CW-1:0]               j_next;
   logic [CW-1:0]               k_next;

   // The shared comparator: held key against the key just read.
   assign key_greater = key_i_ff > $signed(rd_data);

   assign count_next = count_ff + 1'b1;
   assign i_next     = i_ff + 1'b1;
   assign j_next     = j_ff + 1'b1;
   assign k_next     = k_ff + 1'b1;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         num_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         num_ff   <= num_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // The held key is payload and needs no reset.
   always_ff @(posedge clock) begin
      key_i_ff <= key_i_in;
   end

   // Next state and outputs.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      num_in     = num_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      key_i_in   = key_i_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      rsp_final  = 1'b0;
      cmd.wr_en  = 1'b0;
      cmd.rd_en  = 1'b0;
      wr_addr    = i_ff[AW-1:0];
      wr_data    = key_i_ff;
      rd_addr    = i_ff[AW-1:0];

      unique case (state_ff)
         // Take one key per request; the set ends on its mark or when full.
         // No request is taken while reset is held.
         ST_LOAD: begin
            req_ready = !reset;
            wr_addr   = count_ff[AW-1:0];
            wr_data   = req_key;
            if (req_valid && !reset) begin
               cmd.wr_en = 1'b1;
               if (req_end || (count_next == CW'(MAX_KEYS))) begin
                  num_in   = count_next;
                  count_in = '0;
                  i_in     = '0;
                  state_in = ST_FETCH_I;
               end else begin
                  count_in = count_next;
               end
            end
         end

         // Read the key at position i.
         ST_FETCH_I: begin
            cmd.rd_en = 1'b1;
            rd_addr   = i_ff[AW-1:0];
            state_in  = ST_HOLD_I;
         end

         // Hold it as the running minimum for position i.
         ST_HOLD_I: begin
            key_i_in = $signed(rd_data);
            j_in     = i_next;
            if (i_next < num_ff) begin
               state_in = ST_FETCH_J;
            end else begin
               state_in = ST_STORE_I;
            end
         end

         // Read the key at a later position j.
         ST_FETCH_J: begin
            cmd.rd_en = 1'b1;
            rd_addr   = j_ff[AW-1:0];
            state_in  = ST_CMP_J;
         end

         // Swap when the held key is greater: it goes to j, the smaller one is held.
         ST_CMP_J: begin
            wr_addr = j_ff[AW-1:0];
            wr_data = key_i_ff;
            if (key_greater) begin
               cmd.wr_en = 1'b1;
               key_i_in  = $signed(rd_data);
            end
            j_in = j_next;
            if (j_next < num_ff) begin
               state_in = ST_FETCH_J;
            end else begin
               state_in = ST_STORE_I;
            end
         end

         // Write the minimum back to position i and move on.
         ST_STORE_I: begin
            cmd.wr_en = 1'b1;
            wr_addr   = i_ff[AW-1:0];
            wr_data   = key_i_ff;
            i_in      = i_next;
            if (i_next < num_ff) begin
               state_in = ST_FETCH_I;
            end else begin
               k_in     = '0;
               state_in = ST_EMIT_RD;
            end
         end

         // Read the next sorted key into the output register.
         ST_EMIT_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = k_ff[AW-1:0];
            state_in  = ST_EMIT_OUT;
         end

         // Offer it until taken; the last one returns the block to loading.
         ST_EMIT_OUT: begin
            rsp_valid = !reset;
            rsp_final = (k_next == num_ff);
            if (rsp_ready) begin
               if (k_next == num_ff) begin
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_next;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule
